FILE: rtl/necir_pkg.sv
// Shared types and constants for the NEC infrared pulse decoder.
// No dependencies; compiled first.
`default_nettype none

package necir_pkg;

    // Frame geometry
    localparam int FRAME_EDGES   = 33;
    localparam int INTERVAL_BITS = 16;
    localparam int EDGE_W        = $clog2(FRAME_EDGES);

    // Port widths fixed by the field definitions
    localparam int INTERVAL_W = 16;
    localparam int CFG_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;

    // Width of the window comparisons
    localparam int USE_W = (INTERVAL_BITS < INTERVAL_W) ? INTERVAL_BITS : INTERVAL_W;
    localparam int CMP_W = (USE_W > CFG_W) ? USE_W : CFG_W;

    // Edge positions of the two byte fields
    localparam logic [EDGE_W-1:0] ADDR_FIRST = EDGE_W'(2);
    localparam logic [EDGE_W-1:0] ADDR_LAST  = EDGE_W'(9);
    localparam logic [EDGE_W-1:0] CMD_FIRST  = EDGE_W'(18);
    localparam logic [EDGE_W-1:0] CMD_LAST   = EDGE_W'(25);
    localparam logic [EDGE_W-1:0] LAST_EDGE  = EDGE_W'(FRAME_EDGES - 1);

    localparam logic [BYTE_W-1:0] SYNC_BYTE = '1;

    // Register reset values
    localparam logic [CFG_W-1:0] ONE_MIN_RST  = CFG_W'(1800);
    localparam logic [CFG_W-1:0] ONE_MAX_RST  = CFG_W'(2700);
    localparam logic [CFG_W-1:0] ZERO_MIN_RST = CFG_W'(900);
    localparam logic [CFG_W-1:0] ZERO_MAX_RST = CFG_W'(1400);
    localparam logic [CFG_W-1:0] SYNC_MIN_RST = CFG_W'(10800);
    localparam logic [CFG_W-1:0] SYNC_MAX_RST = CFG_W'(16000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_MIN  = 3'd0,
        REG_ONE_MAX  = 3'd1,
        REG_ZERO_MIN = 3'd2,
        REG_ZERO_MAX = 3'd3,
        REG_SYNC_MIN = 3'd4,
        REG_SYNC_MAX = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] one_min;
        logic [CFG_W-1:0] one_max;
        logic [CFG_W-1:0] zero_min;
        logic [CFG_W-1:0] zero_max;
        logic [CFG_W-1:0] sync_min;
        logic [CFG_W-1:0] sync_max;
    } windows_t;

    typedef struct packed {
        logic bit_val;
        logic sync;
    } class_t;

endpackage

`default_nettype wire

FILE: rtl/necir_interval_if.sv
// Input channel: one measured interval per transfer.
// Depends on necir_pkg.
`default_nettype none

interface necir_interval_if;
    logic                               valid;
    logic                               ready;
    logic [necir_pkg::INTERVAL_W-1:0]   interval;

    modport source (output valid, output interval, input ready);
    modport sink   (input valid, input interval, output ready);
endinterface

`default_nettype wire

FILE: rtl/necir_frame_if.sv
// Output channel: decoded address and command per frame.
// Depends on necir_pkg.
`default_nettype none

interface necir_frame_if;
    logic                           valid;
    logic                           ready;
    logic [necir_pkg::BYTE_W-1:0]   address;
    logic [necir_pkg::BYTE_W-1:0]   command;

    modport source (output valid, output address, output command, input ready);
    modport sink   (input valid, input address, input command, output ready);
endinterface

`default_nettype wire

FILE: rtl/necir_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on necir_pkg.
`default_nettype none

interface necir_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [necir_pkg::CFG_IDX_W-1:0]    index;
    logic [necir_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/necir_cfg_regs.sv
// Window bound registers written through the configuration channel.
// Depends on necir_pkg and necir_cfg_if.
`default_nettype none

module necir_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    necir_cfg_if.sink           cfg,
    output necir_pkg::windows_t win
);
    import necir_pkg::*;

    windows_t win_reg;
    windows_t win_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        win_next = win_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_ONE_MIN:  win_next.one_min  = cfg.data;
                REG_ONE_MAX:  win_next.one_max  = cfg.data;
                REG_ZERO_MIN: win_next.zero_min = cfg.data;
                REG_ZERO_MAX: win_next.zero_max = cfg.data;
                REG_SYNC_MIN: win_next.sync_min = cfg.data;
                REG_SYNC_MAX: win_next.sync_max = cfg.data;
                default:      win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.one_min  <= ONE_MIN_RST;
            win_reg.one_max  <= ONE_MAX_RST;
            win_reg.zero_min <= ZERO_MIN_RST;
            win_reg.zero_max <= ZERO_MAX_RST;
            win_reg.sync_min <= SYNC_MIN_RST;
            win_reg.sync_max <= SYNC_MAX_RST;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

`default_nettype wire

FILE: rtl/necir_classify.sv
// Window classifier: one window wins over zero window, zero over sync.
// Depends on necir_pkg.
`default_nettype none

module necir_classify (
    input  wire logic [necir_pkg::INTERVAL_W-1:0] interval,
    input  wire necir_pkg::windows_t              win,
    output necir_pkg::class_t                     cls
);
    import necir_pkg::*;

    logic [CMP_W-1:0] v;
    logic             in_one;
    logic             in_zero;
    logic             in_sync;

    always_comb
    begin
        v       = CMP_W'(interval[USE_W-1:0]);
        in_one  = (v >= CMP_W'(win.one_min))  && (v <= CMP_W'(win.one_max));
        in_zero = (v >= CMP_W'(win.zero_min)) && (v <= CMP_W'(win.zero_max));
        in_sync = (v >= CMP_W'(win.sync_min)) && (v <= CMP_W'(win.sync_max));
        cls.bit_val = in_one;
        cls.sync    = !in_one && !in_zero && in_sync;
    end

endmodule

`default_nettype wire

FILE: rtl/necir_frame.sv
// Frame assembly: input register, edge counter, byte shifters, result register.
// Depends on necir_pkg, necir_classify and the channel interfaces.
`default_nettype none

module necir_frame (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire necir_pkg::windows_t win,
    necir_interval_if.sink           pulse,
    necir_frame_if.source            frame
);
    import necir_pkg::*;

    logic                  in_valid_reg;
    logic [INTERVAL_W-1:0] in_data_reg;
    logic [EDGE_W-1:0]     edge_count_reg;
    logic [EDGE_W-1:0]     edge_count_next;
    logic [BYTE_W-1:0]     addr_shift_reg;
    logic [BYTE_W-1:0]     addr_shift_next;
    logic [BYTE_W-1:0]     cmd_shift_reg;
    logic [BYTE_W-1:0]     cmd_shift_next;
    logic                  addr_sync_reg;
    logic                  addr_sync_next;
    logic                  cmd_sync_reg;
    logic                  cmd_sync_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [BYTE_W-1:0]     out_addr_reg;
    logic [BYTE_W-1:0]     out_addr_next;
    logic [BYTE_W-1:0]     out_cmd_reg;
    logic [BYTE_W-1:0]     out_cmd_next;

    class_t cls;
    logic   frame_end;
    logic   in_addr;
    logic   in_cmd;
    logic   advance;
    logic   load;

    necir_classify u_classify (
        .interval (in_data_reg),
        .win      (win),
        .cls      (cls)
    );

    assign frame_end = (edge_count_reg == LAST_EDGE);
    assign in_addr   = (edge_count_reg >= ADDR_FIRST) && (edge_count_reg <= ADDR_LAST);
    assign in_cmd    = (edge_count_reg >= CMD_FIRST) && (edge_count_reg <= CMD_LAST);

    // Only a frame-ending item waits on a full result register
    assign advance = in_valid_reg && (!frame_end || !out_valid_reg || frame.ready);
    assign load    = pulse.valid && pulse.ready;

    assign pulse.ready = !in_valid_reg || advance;

    always_comb
    begin
        edge_count_next = edge_count_reg;
        addr_shift_next = addr_shift_reg;
        cmd_shift_next  = cmd_shift_reg;
        addr_sync_next  = addr_sync_reg;
        cmd_sync_next   = cmd_sync_reg;
        if (advance)
        begin
            if (frame_end)
            begin
                edge_count_next = '0;
                addr_shift_next = '0;
                cmd_shift_next  = '0;
                addr_sync_next  = 1'b0;
                cmd_sync_next   = 1'b0;
            end
            else
            begin
                edge_count_next = edge_count_reg + EDGE_W'(1);
                if (in_addr)
                begin
                    addr_shift_next = {addr_shift_reg[BYTE_W-2:0], cls.bit_val};
                    addr_sync_next  = addr_sync_reg || cls.sync;
                end
                else if (in_cmd)
                begin
                    cmd_shift_next = {cmd_shift_reg[BYTE_W-2:0], cls.bit_val};
                    cmd_sync_next  = cmd_sync_reg || cls.sync;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !frame.ready;
        out_addr_next  = out_addr_reg;
        out_cmd_next   = out_cmd_reg;
        if (advance && frame_end)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = addr_sync_reg ? SYNC_BYTE : addr_shift_reg;
            out_cmd_next   = cmd_sync_reg ? SYNC_BYTE : cmd_shift_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            edge_count_reg <= '0;
            addr_shift_reg <= '0;
            cmd_shift_reg  <= '0;
            addr_sync_reg  <= 1'b0;
            cmd_sync_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= load || (in_valid_reg && !advance);
            edge_count_reg <= edge_count_next;
            addr_shift_reg <= addr_shift_next;
            cmd_shift_reg  <= cmd_shift_next;
            addr_sync_reg  <= addr_sync_next;
            cmd_sync_reg   <= cmd_sync_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_data_reg <= pulse.interval;
        end
        out_addr_reg <= out_addr_next;
        out_cmd_reg  <= out_cmd_next;
    end

    assign frame.valid   = out_valid_reg;
    assign frame.address = out_addr_reg;
    assign frame.command = out_cmd_reg;

    // Counter wraps at the frame-ending edge and never runs past it
    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= LAST_EDGE)
        else $error("edge count beyond frame end");

    a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_end |=> edge_count_reg == '0 && !addr_sync_reg && !cmd_sync_reg)
        else $error("frame state not cleared after result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance) && $past(frame_end))
        else $error("result raised without a frame-ending edge");

    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg)
            && $stable(edge_count_reg))
        else $error("stalled item lost or state moved");

endmodule

`default_nettype wire

FILE: rtl/nec_ir_pulse_decoder.sv
// NEC infrared pulse decoder: one interval per falling edge in, address and command out.
// A frame-ending interval goes through the input register, then the result register.
// Throughput: one interval per cycle; only a frame-ending interval waits on a held result.
// Reset (rst_n, asynchronous): edge count and bytes cleared, window bounds to defaults.
// Depends on necir_pkg, the channel interfaces, necir_cfg_regs and necir_frame.
`default_nettype none

module nec_ir_pulse_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    necir_interval_if.sink  pulse,
    necir_frame_if.source   frame,
    necir_cfg_if.sink       cfg
);
    import necir_pkg::*;

    windows_t win;

    necir_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .win   (win)
    );

    necir_frame u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .win   (win),
        .pulse (pulse),
        .frame (frame)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for nec_ir_pulse_decoder: decodes frames in a scoreboard class
// and compares every frame transfer with it. Needs necir_pkg, the three channel
// interfaces and the decoder RTL.
`default_nettype none

module tb_top;
    import necir_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_PHASE   = 2;
    localparam int REPORT_MAX   = 10;

    // indexes the decoder has no register behind
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int unsigned {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_RHYTHM
    } ready_mode_e;

    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
    } decoded_frame_t;

    class nec_frame_checker;
        windows_t           win;
        logic [EDGE_W-1:0]  edge_pos;
        logic [BYTE_W-1:0]  addr_bits;
        logic [BYTE_W-1:0]  cmd_bits;
        bit                 addr_sync;
        bit                 cmd_sync;
        decoded_frame_t     pending_frames[$];
        int unsigned        intervals_seen;
        int unsigned        frames_checked;
        int unsigned        errors;

        function new();
            win = {ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                   SYNC_MIN_RST, SYNC_MAX_RST};
            clear_frame();
        endfunction

        function void clear_frame();
            edge_pos  = '0;
            addr_bits = '0;
            cmd_bits  = '0;
            addr_sync = 1'b0;
            cmd_sync  = 1'b0;
        endfunction

        function void set_window(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_ONE_MIN:  win.one_min  = value;
                REG_ONE_MAX:  win.one_max  = value;
                REG_ZERO_MIN: win.zero_min = value;
                REG_ZERO_MAX: win.zero_max = value;
                REG_SYNC_MIN: win.sync_min = value;
                REG_SYNC_MAX: win.sync_max = value;
                default: ;
            endcase
        endfunction

        function bit in_band(logic [CMP_W-1:0] v, logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
            return (v >= CMP_W'(lo)) && (v <= CMP_W'(hi));
        endfunction

        // one window has priority, then zero, then sync
        function class_t classify(logic [CMP_W-1:0] v);
            class_t c;
            c = '0;
            if (in_band(v, win.one_min, win.one_max))
                c.bit_val = 1'b1;
            else if (!in_band(v, win.zero_min, win.zero_max)
                     && in_band(v, win.sync_min, win.sync_max))
                c.sync = 1'b1;
            return c;
        endfunction

        function void note_interval(logic [INTERVAL_W-1:0] interval);
            logic [CMP_W-1:0] v;
            class_t           c;
            decoded_frame_t   f;
            v = CMP_W'(interval[USE_W-1:0]);
            intervals_seen++;
            if (edge_pos >= LAST_EDGE) begin
                f.address = addr_sync ? SYNC_BYTE : addr_bits;
                f.command = cmd_sync ? SYNC_BYTE : cmd_bits;
                pending_frames.push_back(f);
                clear_frame();
                return;
            end
            c = classify(v);
            if (edge_pos >= ADDR_FIRST && edge_pos <= ADDR_LAST) begin
                addr_bits = {addr_bits[BYTE_W-2:0], c.bit_val};
                if (c.sync)
                    addr_sync = 1'b1;
            end
            else if (edge_pos >= CMD_FIRST && edge_pos <= CMD_LAST) begin
                cmd_bits = {cmd_bits[BYTE_W-2:0], c.bit_val};
                if (c.sync)
                    cmd_sync = 1'b1;
            end
            edge_pos = edge_pos + EDGE_W'(1);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function void check_frame(logic [BYTE_W-1:0] address, logic [BYTE_W-1:0] command);
            decoded_frame_t exp_f;
            if (pending_frames.size() == 0) begin
                flag($sformatf("unexpected frame address %02h command %02h", address, command));
                return;
            end
            exp_f = pending_frames.pop_front();
            frames_checked++;
            if (address !== exp_f.address || command !== exp_f.command)
                flag($sformatf("frame %0d: address exp %02h got %02h, command exp %02h got %02h",
                               frames_checked, exp_f.address, address, exp_f.command, command));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    necir_interval_if pulse_ch();
    necir_frame_if    frame_ch();
    necir_cfg_if      cfg_ch();

    nec_ir_pulse_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pulse (pulse_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    nec_frame_checker tracker;

    int unsigned  cycles;
    int unsigned  burst_left;
    int unsigned  cfg_writes;
    int unsigned  hold_left;
    int unsigned  mode_left;
    bit           hold_now;
    bit           no_gaps;
    ready_mode_e  ready_mode;

    // one default-window frame: edges of every window, out-of-window values,
    // a sync in the command byte followed by more bits, sync on the last edge
    logic [INTERVAL_W-1:0] directed_edges [FRAME_EDGES] = '{
        16'd0, 16'd65535,
        16'd1800, 16'd2700, 16'd900, 16'd1400, 16'd1799, 16'd2701, 16'd1401, 16'd2000,
        16'd10800, 16'd16000, 16'd65535, 16'd0, 16'd1800, 16'd899, 16'd16001, 16'd10799,
        16'd2000, 16'd10800, 16'd1800, 16'd2700, 16'd16000, 16'd16001, 16'd10799, 16'd0,
        16'd65535, 16'd0, 16'd1000, 16'd43690, 16'd21845, 16'd2200,
        16'd10800
    };

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("nec_ir_pulse_decoder test failed");
            $finish;
        end
    end

    // frame receiver: changing stall patterns, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_now) begin
            hold_now  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            frame_ch.ready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_e'($urandom_range(RDY_RHYTHM));
                mode_left  = $urandom_range(200, 32);
            end
            mode_left--;
            case (ready_mode)
                RDY_ALWAYS: frame_ch.ready <= 1'b1;
                RDY_COIN:   frame_ch.ready <= 1'($urandom_range(1));
                RDY_SPARSE: frame_ch.ready <= ($urandom_range(3) == 0);
                default:    frame_ch.ready <= (cycles % 5 != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
            tracker.check_frame(frame_ch.address, frame_ch.command);
    end

    task automatic offer_interval(input logic [INTERVAL_W-1:0] v);
        int unsigned gap;
        if (burst_left == 0) begin
            if (no_gaps) begin
                burst_left = 1000;
                gap        = 0;
            end
            else if ($urandom_range(5) == 0) begin
                burst_left = $urandom_range(100, 40);
                gap        = $urandom_range(1);
            end
            else begin
                burst_left = $urandom_range(16, 1);
                gap        = $urandom_range(5);
            end
            if (gap != 0) begin
                pulse_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pulse_ch.valid    <= 1'b1;
        pulse_ch.interval <= v;
        @(posedge clk);
        while (!pulse_ch.ready)
            @(posedge clk);
        tracker.note_interval(v);
    endtask

    // stop offering and let every frame and any trailing edge work out
    task automatic settle();
        pulse_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        tracker.set_window(idx, value);
        cfg_writes++;
    endtask

    task automatic load_windows(input windows_t w, input bit spare_hi);
        write_reg(spare_hi ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
        write_reg(REG_ONE_MIN,  w.one_min);
        write_reg(REG_ONE_MAX,  w.one_max);
        write_reg(REG_ZERO_MIN, w.zero_min);
        write_reg(REG_ZERO_MAX, w.zero_max);
        write_reg(REG_SYNC_MIN, w.sync_min);
        write_reg(REG_SYNC_MAX, w.sync_max);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic windows_t window_setting(int unsigned phase);
        windows_t          w;
        logic [CFG_W-1:0]  p[$];
        case (phase)
            0: w = '0;
            1: begin
                // one window a single point at the top, sync covers everything
                w.one_min  = '1;
                w.one_max  = '1;
                w.zero_min = '0;
                w.zero_max = '0;
                w.sync_min = '0;
                w.sync_max = '1;
            end
            HOLD_PHASE: w = {ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                             SYNC_MIN_RST, SYNC_MAX_RST};
            3: begin
                // empty one window
                w.one_min  = '1;
                w.one_max  = '0;
                w.zero_min = '0;
                w.zero_max = CFG_W'(16'h7fff);
                w.sync_min = CFG_W'(16'h8000);
                w.sync_max = '1;
            end
            4, 6: begin
                repeat (6) p.push_back(CFG_W'($urandom_range(65535)));
                p.sort();
                w.zero_min = p[0];
                w.zero_max = p[1];
                w.one_min  = p[2];
                w.one_max  = p[3];
                w.sync_min = p[4];
                w.sync_max = p[5];
            end
            default: w = windows_t'({$urandom, $urandom, $urandom});
        endcase
        return w;
    endfunction

    // mostly well-classified bits in the byte fields, mostly random values elsewhere
    function automatic logic [INTERVAL_W-1:0] pick_interval();
        int unsigned        r;
        logic [CFG_W-1:0]   lo;
        logic [CFG_W-1:0]   hi;
        logic [EDGE_W-1:0]  pos;
        windows_t           w;
        bit                 in_field;
        w   = tracker.win;
        pos = tracker.edge_pos;
        r   = $urandom_range(99);
        in_field = (pos >= ADDR_FIRST && pos <= ADDR_LAST)
                   || (pos >= CMD_FIRST && pos <= CMD_LAST);
        if ((!in_field && r < 50) || r >= 92)
            return INTERVAL_W'($urandom_range(65535));
        if (r >= 82) begin
            case ($urandom_range(5))
                0: lo = w.one_min;
                1: lo = w.one_max;
                2: lo = w.zero_min;
                3: lo = w.zero_max;
                4: lo = w.sync_min;
                default: lo = w.sync_max;
            endcase
            lo = lo + CFG_W'($urandom_range(2));
            return INTERVAL_W'(lo - CFG_W'(1));
        end
        if (r < 40) begin
            lo = w.one_min;
            hi = w.one_max;
        end
        else if (r < 75) begin
            lo = w.zero_min;
            hi = w.zero_max;
        end
        else begin
            lo = w.sync_min;
            hi = w.sync_max;
        end
        if (lo > hi)
            return INTERVAL_W'($urandom_range(65535));
        return INTERVAL_W'($urandom_range(hi, lo));
    endfunction

    initial begin
        tracker           = new();
        rst_n             = 1'b0;
        pulse_ch.valid    = 1'b0;
        pulse_ch.interval = '0;
        frame_ch.ready    = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        cycles            = 0;
        burst_left        = 0;
        cfg_writes        = 0;
        hold_left         = 0;
        mode_left         = 0;
        hold_now          = 1'b0;
        no_gaps           = 1'b0;
        ready_mode        = RDY_ALWAYS;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_edges[i])
            offer_interval(directed_edges[i]);
        settle();

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            load_windows(window_setting(phase), phase[0]);
            if (phase == HOLD_PHASE) begin
                // long receiver stall while intervals keep coming
                hold_now = 1'b1;
                no_gaps  = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 100)
                    no_gaps = 1'b0;
                offer_interval(pick_interval());
            end
            settle();
        end

        $display("covered %0d intervals and %0d decoded frames over %0d window settings",
                 tracker.intervals_seen, tracker.frames_checked, PHASES + 1);
        $display("%0d register writes, %0d mismatches, %0d frames outstanding",
                 cfg_writes, tracker.errors, tracker.pending_frames.size());
        if (tracker.errors == 0 && tracker.pending_frames.size() == 0)
            $display("nec_ir_pulse_decoder test passed");
        else
            $display("nec_ir_pulse_decoder test failed");
        $finish;
    end
endmodule

`default_nettype wire

FILE: filelist.f
rtl/necir_pkg.sv
rtl/necir_interval_if.sv
rtl/necir_frame_if.sv
rtl/necir_cfg_if.sv
rtl/necir_cfg_regs.sv
rtl/necir_classify.sv
rtl/necir_frame.sv
rtl/nec_ir_pulse_decoder.sv
tb/sv/tb_top.sv
